// ----- sv/fopm_pkg.sv -----
// ----------------------------------------------------------------------------
// fopm_pkg
// Shared constants and controller/datapath interface types of the
// fourth-order PDM modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fopm_pkg;

    localparam int OVERSAMPLE = 32;
    localparam int CNT_W      = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;

    // input offset, threshold and correction
    localparam logic signed [WORD_W-1:0] VMIN   = -32'sd98301;
    localparam logic signed [WORD_W-1:0] THRESH = -32'sd100660224;
    localparam logic [WORD_W-1:0]        CORR   = 32'd196602;

    // error term folded over the history words:
    // e = 1024*d + 1061*h0 - 2667*h1 + 2287*h2 - 665*h3
    localparam logic [WORD_W-1:0] K_H0 = 32'd1061;
    localparam logic [WORD_W-1:0] K_H1 = 32'd2667;
    localparam logic [WORD_W-1:0] K_H2 = 32'd2287;
    localparam logic [WORD_W-1:0] K_H3 = 32'd665;

    typedef struct packed {
        logic load;
        logic step_wn;
        logic step_err;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/fopm_datapath.sv -----
// ----------------------------------------------------------------------------
// fopm_datapath
// History words, two-phase loop iteration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fopm_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire fopm_pkg::cmd_t                 cmd,
    output fopm_pkg::status_t                   status,
    input  wire logic [fopm_pkg::SAMPLE_W-1:0]  sample,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [fopm_pkg::WORD_W-1:0]         m_tdata
);

    logic [fopm_pkg::WORD_W-1:0] h0_reg, h1_reg, h2_reg, h3_reg;
    logic [fopm_pkg::WORD_W-1:0] d_reg, d_sh_reg;
    logic [fopm_pkg::WORD_W-1:0] wn_reg, q_reg;
    logic [fopm_pkg::WORD_W-1:0] bits_reg;
    logic [fopm_pkg::WORD_W-1:0] out_reg;
    logic                        out_valid_reg;

    logic [fopm_pkg::WORD_W-1:0] smp_ext;
    logic [fopm_pkg::WORD_W-1:0] d_next;
    logic [fopm_pkg::WORD_W-1:0] wn_next;
    logic [fopm_pkg::WORD_W-1:0] q_next;
    logic [fopm_pkg::WORD_W-1:0] e_val;
    logic                        hit;

    assign smp_ext = {{(fopm_pkg::WORD_W-fopm_pkg::SAMPLE_W){sample[fopm_pkg::SAMPLE_W-1]}},
                      sample};
    assign d_next  = fopm_pkg::VMIN - smp_ext;

    assign wn_next = d_reg + ((h0_reg + h2_reg) << 2) - (h1_reg * 32'd6) - h3_reg;
    assign q_next  = (h0_reg * fopm_pkg::K_H0) - (h1_reg * fopm_pkg::K_H1);
    assign e_val   = d_sh_reg + q_reg + (h2_reg * fopm_pkg::K_H2) - (h3_reg * fopm_pkg::K_H3);
    assign hit     = $signed(e_val) < fopm_pkg::THRESH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h0_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
            h3_reg <= '0;
        end else if (cmd.step_err) begin
            h3_reg <= h2_reg;
            h2_reg <= h1_reg;
            h1_reg <= h0_reg;
            h0_reg <= wn_reg + (hit ? fopm_pkg::CORR : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg    <= d_next;
            d_sh_reg <= d_next << 10;
            bits_reg <= '0;
        end
        if (cmd.step_wn) begin
            wn_reg <= wn_next;
            q_reg  <= q_next;
        end
        if (cmd.step_err) begin
            bits_reg <= {bits_reg[fopm_pkg::WORD_W-2:0], hit};
        end
        if (cmd.out_load) begin
            out_reg <= bits_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_reg;

endmodule

`default_nettype wire

// ----- sv/fopm_ctrl.sv -----
// ----------------------------------------------------------------------------
// fopm_ctrl
// Sequencer for the oversampled loop: accept, iterate in two phases, hand off.
// ----------------------------------------------------------------------------
`default_nettype none

module fopm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output fopm_pkg::cmd_t         cmd,
    input  wire fopm_pkg::status_t status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WN    = 4'b0010,
        S_ERR   = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [fopm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       last;

    assign last = cnt_reg == fopm_pkg::CNT_W'(fopm_pkg::OVERSAMPLE - 1);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_WN;
                end
            end
            S_WN: begin
                cmd.step_wn = 1'b1;
                state_next  = S_ERR;
            end
            S_ERR: begin
                cmd.step_err = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                state_next   = last ? S_FLUSH : S_WN;
            end
            S_FLUSH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fourth_order_pdm_modulator_core.sv -----
// ----------------------------------------------------------------------------
// fourth_order_pdm_modulator_core
// Fourth-order delta-sigma PDM modulator: one 16-bit sample in, one
// 32-bit PDM word out, first iteration in the most significant bit.
// ----------------------------------------------------------------------------
// Sequence: S_IDLE loads the sample, then OVERSAMPLE loop iterations run, each
// in two phases (S_WN, S_ERR); S_FLUSH then loads the output register once free.
// A new sample is accepted only in S_IDLE, after the previous word has left S_FLUSH.
// The next item is accepted while a finished word waits on m_tready.
// Reset: aresetn synchronous, active low; clears history, sequencer and m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module fourth_order_pdm_modulator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] pdm_bits
);

    fopm_pkg::cmd_t    cmd;
    fopm_pkg::status_t status;

    fopm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fopm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .sample   (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while loop running");

    a_result_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result handed off without ending the run");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
